// ----- src/rmbd_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rmbd_pkg
// Shared types and constants of the mip-level box downsampler.
// ---------------------------------------------------------------------------
package rmbd_pkg;

    localparam int DEF_MAX_WIDTH = 4096;
    localparam int HEIGHT_LIMIT  = 4096;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 13;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OPAQUE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_NORMAL = 2'd3;

    // word handed from the front end to the back end
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       last;
        logic       normal;
    } avg_word_t;

endpackage

// ----- src/rmbd_front.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rmbd_front
// Pixel intake: position counters, pair sums, line store and quad averages.
// ---------------------------------------------------------------------------
module rmbd_front
    import rmbd_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [7:0]            s_in_red,
    input  logic [7:0]            s_in_green,
    input  logic [7:0]            s_in_blue,
    input  logic [7:0]            s_in_alpha,
    output logic                  q_valid,
    input  logic                  q_ready,
    output avg_word_t             q_word
);

    localparam int DEPTH = (MAX_WIDTH / 2 > 0) ? MAX_WIDTH / 2 : 1;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(MAX_WIDTH + 1);
    localparam int WW    = (CW > 13) ? CW : 13;

    logic [12:0] width_reg, height_reg;
    logic        opaque_reg, normal_reg;
    logic [CW-1:0] col_reg, col_next;
    logic [11:0] row_reg, row_next;
    logic [31:0] left_reg;
    logic [35:0] line_mem [DEPTH];
    logic [35:0] rd_reg;

    // stage 2 holding register
    logic        s2_valid_reg;
    logic [35:0] s2_pair_reg;
    logic        s2_last_reg, s2_norm_reg;

    logic [CW-1:0] eff_w;
    logic [12:0]   eff_h;
    logic [7:0]    alpha_in;
    logic [35:0]   pair;
    logic          accept, odd_col, odd_row, emit, s2_go;
    logic [CW-2:0] slot;
    logic [WW-1:0] w_ext;

    always_comb begin
        w_ext = WW'(width_reg);
        if (width_reg == 13'd0)
            eff_w = CW'(1);
        else if (w_ext > WW'(MAX_WIDTH))
            eff_w = CW'(MAX_WIDTH);
        else
            eff_w = CW'(width_reg);
        if (height_reg == 13'd0)
            eff_h = 13'd1;
        else if (height_reg > 13'(HEIGHT_LIMIT))
            eff_h = 13'(HEIGHT_LIMIT);
        else
            eff_h = height_reg;
    end

    assign alpha_in = opaque_reg ? 8'hFF : s_in_alpha;
    assign odd_col  = col_reg[0];
    assign odd_row  = row_reg[0];
    assign slot     = col_reg[CW-1:1];
    assign pair = {9'(left_reg[31:24]) + 9'(s_in_red),
                   9'(left_reg[23:16]) + 9'(s_in_green),
                   9'(left_reg[15:8])  + 9'(s_in_blue),
                   9'(left_reg[7:0])   + 9'(alpha_in)};

    // stage 2 drains when the queue takes it
    assign s2_go   = s2_valid_reg && q_ready;
    assign s_ready = !s2_valid_reg || q_ready;
    assign accept  = s_valid && s_ready;
    assign emit    = accept && odd_col && odd_row;

    always_comb begin
        col_next = col_reg + CW'(1);
        row_next = row_reg;
        if (col_next >= eff_w) begin
            col_next = '0;
            row_next = row_reg + 12'd1;
            if (13'(row_next) >= eff_h)
                row_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg    <= 13'd2;
            height_reg   <= 13'd2;
            opaque_reg   <= 1'b1;
            normal_reg   <= 1'b0;
            col_reg      <= '0;
            row_reg      <= '0;
            s2_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_WIDTH: begin
                        width_reg <= cfg_data;
                        col_reg   <= '0;
                        row_reg   <= '0;
                    end
                    REG_HEIGHT: begin
                        height_reg <= cfg_data;
                        col_reg    <= '0;
                        row_reg    <= '0;
                    end
                    REG_OPAQUE: opaque_reg <= cfg_data[0];
                    REG_NORMAL: normal_reg <= cfg_data[0];
                    default: ;
                endcase
            end
            if (emit)
                s2_valid_reg <= 1'b1;
            else if (s2_go)
                s2_valid_reg <= 1'b0;
        end
    end

    // line store: write on even rows, registered read on odd rows
    always_ff @(posedge aclk) begin
        if (accept && !odd_col)
            left_reg <= {s_in_red, s_in_green, s_in_blue, alpha_in};
        if (accept && odd_col && !odd_row)
            line_mem[AW'(slot)] <= pair;
        if (emit)
            rd_reg <= line_mem[AW'(slot)];
        if (emit) begin
            s2_pair_reg <= pair;
            s2_last_reg <= (CW'(slot) == (eff_w >> 1) - CW'(1)) &&
                           (13'(row_reg >> 1) == (eff_h >> 1) - 13'd1);
            s2_norm_reg <= normal_reg;
        end
    end

    logic [9:0] sr, sg, sb, sa;
    always_comb begin
        sr = 10'(rd_reg[35:27]) + 10'(s2_pair_reg[35:27]);
        sg = 10'(rd_reg[26:18]) + 10'(s2_pair_reg[26:18]);
        sb = 10'(rd_reg[17:9])  + 10'(s2_pair_reg[17:9]);
        sa = 10'(rd_reg[8:0])   + 10'(s2_pair_reg[8:0]);
        q_word = '{red: sr[9:2], green: sg[9:2], blue: sb[9:2], alpha: sa[9:2],
                   last: s2_last_reg, normal: s2_norm_reg};
    end
    assign q_valid = s2_valid_reg;

    property p_emit_blocks;
        @(posedge aclk) disable iff (!aresetn) (s2_valid_reg && !q_ready) |-> !s_ready;
    endproperty
    a_emit_blocks: assert property (p_emit_blocks) else $error("front overrun");
    a_emit_sets: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |=> s2_valid_reg) else $error("lost quad");
    a_col_range: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && !cfg_we |=> col_reg < eff_w) else $error("column overflow");

endmodule

// ----- src/rmbd_fifo.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rmbd_fifo
// Two-entry queue between front and back end.
// ---------------------------------------------------------------------------
module rmbd_fifo
    import rmbd_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  avg_word_t in_word,
    output logic      out_valid,
    input  logic      out_ready,
    output avg_word_t out_word
);

    avg_word_t  mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign in_ready  = cnt_reg != 2'd2;
    assign out_valid = cnt_reg != 2'd0;
    assign out_word  = mem_reg[rp_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) wp_reg <= !wp_reg;
            if (pop)  rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wp_reg] <= in_word;
    end

    a_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != 2'd3) else $error("queue count");

endmodule

// ----- src/rmbd_back.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rmbd_back
// Normal renormalisation sequencer and output register.
// ---------------------------------------------------------------------------
module rmbd_back
    import rmbd_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      q_valid,
    output logic      q_ready,
    input  avg_word_t q_word,
    output logic      m_valid,
    input  logic      m_ready,
    output logic [7:0] m_out_red,
    output logic [7:0] m_out_green,
    output logic [7:0] m_out_blue,
    output logic [7:0] m_out_alpha,
    output logic       m_last_of_level
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MAG  = 3'd1;
    localparam logic [2:0] ST_SQ   = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_SQRT = 3'd4;
    localparam logic [2:0] ST_MUL  = 3'd5;
    localparam logic [2:0] ST_OUT  = 3'd6;

    logic [2:0]  state_reg;
    avg_word_t   w_reg;
    logic [1:0]  ch_reg;
    logic [2:0]  neg_reg;
    logic [14:0] mag_reg [3];
    logic [30:0] s_reg;
    logic [60:0] rem_reg;
    logic [60:0] quo_reg;
    logic [5:0]  it_reg;
    logic [61:0] x_reg;
    logic [47:0] res_reg;
    logic [61:0] bit_reg;
    logic [7:0]  o_reg [3];

    logic        ov_reg;
    logic [7:0]  or_reg, og_reg, ob_reg, oa_reg;
    logic        ol_reg;

    logic [7:0]  a_cur;
    logic [23:0] num_abs;
    logic [14:0] mag_cur;
    logic [61:0] trial_rem;
    logic [61:0] tsum;
    logic [46:0] prod;
    logic [30:0] nmag;
    logic signed [32:0] biased;
    logic [40:0] scaled;
    logic        out_load;

    assign q_ready  = (state_reg == ST_IDLE) && (!ov_reg || m_ready);
    assign out_load = (state_reg == ST_OUT) && (!ov_reg || m_ready);

    always_comb begin
        unique case (ch_reg)
            2'd0:    a_cur = w_reg.red;
            2'd1:    a_cur = w_reg.green;
            default: a_cur = w_reg.blue;
        endcase
        // |2a-255|*16384/255 ; /255 via reciprocal 257/65536 with correction
        num_abs = (a_cur[7] ? 24'({a_cur, 1'b0} - 9'd255) : 24'(9'd255 - {a_cur, 1'b0})) << 14;
        mag_cur = 15'((32'(num_abs) * 32'd257 + 32'd257) >> 16);
        if ((32'(mag_cur) + 32'd1) * 32'd255 <= 32'(num_abs))
            mag_cur = mag_cur + 15'd1;
        else if (32'(mag_cur) * 32'd255 > 32'(num_abs))
            mag_cur = mag_cur - 15'd1;
        trial_rem = {rem_reg, 1'b0};
        tsum      = 62'(res_reg) + bit_reg;
        prod      = 47'(mag_reg[ch_reg]) * 47'(res_reg[31:0]);
        nmag      = 31'(prod >> 16);
        biased    = neg_reg[ch_reg] ? 33'sd16384 - 33'(nmag) : 33'sd16384 + 33'(nmag);
        scaled    = (biased < 0) ? '0 : 41'(biased) * 41'd255;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ov_reg    <= 1'b0;
        end else begin
            if (out_load)
                ov_reg <= 1'b1;
            else if (m_valid && m_ready)
                ov_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE: if (q_valid && q_ready) begin
                    w_reg  <= q_word;
                    ch_reg <= 2'd0;
                    state_reg <= q_word.normal ? ST_MAG : ST_OUT;
                    o_reg[0] <= q_word.red;
                    o_reg[1] <= q_word.green;
                    o_reg[2] <= q_word.blue;
                end
                ST_MAG: begin
                    mag_reg[ch_reg] <= mag_cur;
                    neg_reg[ch_reg] <= !a_cur[7];
                    if (ch_reg == 2'd2) begin
                        ch_reg <= 2'd0;
                        s_reg  <= '0;
                        state_reg <= ST_SQ;
                    end else
                        ch_reg <= ch_reg + 2'd1;
                end
                ST_SQ: begin
                    s_reg <= s_reg + 31'(30'(mag_reg[ch_reg]) * 30'(mag_reg[ch_reg]));
                    if (ch_reg == 2'd2) begin
                        ch_reg  <= 2'd0;
                        rem_reg <= '0;
                        quo_reg <= '0;
                        it_reg  <= 6'd60;
                        state_reg <= ST_DIV;
                    end else
                        ch_reg <= ch_reg + 2'd1;
                end
                ST_DIV: begin
                    if (s_reg == '0)
                        state_reg <= ST_OUT;
                    else begin
                        // restoring divide of 2^60 by S, one bit a cycle
                        if (trial_rem[61:0] + 62'(it_reg == 6'd60) >= 62'(s_reg)) begin
                            rem_reg <= 61'(trial_rem + 62'(it_reg == 6'd60) - 62'(s_reg));
                            quo_reg <= {quo_reg[59:0], 1'b1};
                        end else begin
                            rem_reg <= 61'(trial_rem + 62'(it_reg == 6'd60));
                            quo_reg <= {quo_reg[59:0], 1'b0};
                        end
                        if (it_reg == 6'd0) begin
                            state_reg <= ST_SQRT;
                            bit_reg   <= 62'd1 << 60;
                            res_reg   <= '0;
                            x_reg     <= '0;
                        end else
                            it_reg <= it_reg - 6'd1;
                    end
                end
                ST_SQRT: begin
                    if (bit_reg == 62'd1 << 60 && x_reg == '0)
                        x_reg <= 62'(quo_reg);
                    else begin
                        if (x_reg >= tsum) begin
                            x_reg   <= x_reg - tsum;
                            res_reg <= 48'((62'(res_reg) >> 1) + bit_reg);
                        end else
                            res_reg <= res_reg >> 1;
                        bit_reg <= bit_reg >> 2;
                        if (bit_reg == 62'd1) begin
                            state_reg <= ST_MUL;
                            ch_reg    <= 2'd0;
                        end
                    end
                end
                ST_MUL: begin
                    o_reg[ch_reg] <= ((scaled >> 15) > 41'd255) ? 8'hFF : 8'(scaled >> 15);
                    if (ch_reg == 2'd2)
                        state_reg <= ST_OUT;
                    else
                        ch_reg <= ch_reg + 2'd1;
                end
                ST_OUT: if (out_load) begin
                    or_reg <= o_reg[0];
                    og_reg <= o_reg[1];
                    ob_reg <= o_reg[2];
                    oa_reg <= w_reg.alpha;
                    ol_reg <= w_reg.last;
                    state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid         = ov_reg;
    assign m_out_red       = or_reg;
    assign m_out_green     = og_reg;
    assign m_out_blue      = ob_reg;
    assign m_out_alpha     = oa_reg;
    assign m_last_of_level = ol_reg;

    a_take_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_valid && q_ready) |-> state_reg == ST_IDLE) else $error("busy take");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid) else $error("result dropped");

endmodule

// ----- src/rgba8_mipmap_box_downsampler.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rgba8_mipmap_box_downsampler
// 2x2 box downsampler for RGBA8 mip levels with optional normal renormalising.
// ---------------------------------------------------------------------------
// Pixels enter in raster order at one word a cycle while s_ready is high; the
// front end keeps pair sums of even rows in a line store (one memory port) and
// hands each finished quad average to a two-word queue. In colour mode the
// back end passes each quad straight to its output register, and the steady
// rate is one pixel a cycle while the output takes results. In normal-map
// mode the back end runs a 61-step divide and 31-step square root for each
// output, and the input stalls once the queue is full.
module rgba8_mipmap_box_downsampler
    import rmbd_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [7:0]            s_in_red,
    input  logic [7:0]            s_in_green,
    input  logic [7:0]            s_in_blue,
    input  logic [7:0]            s_in_alpha,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [7:0]            m_out_red,
    output logic [7:0]            m_out_green,
    output logic [7:0]            m_out_blue,
    output logic [7:0]            m_out_alpha,
    output logic                  m_last_of_level
);

    logic      f_valid, f_ready, b_valid, b_ready;
    avg_word_t f_word, b_word;

    rmbd_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
        .aclk, .aresetn, .cfg_we, .cfg_index, .cfg_data,
        .s_valid, .s_ready, .s_in_red, .s_in_green, .s_in_blue, .s_in_alpha,
        .q_valid(f_valid), .q_ready(f_ready), .q_word(f_word)
    );

    rmbd_fifo u_fifo (
        .aclk, .aresetn,
        .in_valid(f_valid), .in_ready(f_ready), .in_word(f_word),
        .out_valid(b_valid), .out_ready(b_ready), .out_word(b_word)
    );

    rmbd_back u_back (
        .aclk, .aresetn,
        .q_valid(b_valid), .q_ready(b_ready), .q_word(b_word),
        .m_valid, .m_ready, .m_out_red, .m_out_green, .m_out_blue,
        .m_out_alpha, .m_last_of_level
    );

endmodule

// ----- tb/rmbd_quad_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rmbd_quad_checker
// Watches the pixel and result channels of the 2x2 box downsampler, predicts
// each downsampled pixel from the accepted input words and compares it field
// by field with what the block hands out.
// ---------------------------------------------------------------------------
module rmbd_quad_checker
    import rmbd_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  logic [7:0]            s_in_red,
    input  logic [7:0]            s_in_green,
    input  logic [7:0]            s_in_blue,
    input  logic [7:0]            s_in_alpha,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  logic [7:0]            m_out_red,
    input  logic [7:0]            m_out_green,
    input  logic [7:0]            m_out_blue,
    input  logic [7:0]            m_out_alpha,
    input  logic                  m_last_of_level,
    output int                    mismatches,
    output int                    pending
);

    localparam int PAIR_SLOTS = MAX_WIDTH / 2;

    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       last;
    } quad_pixel_t;

    quad_pixel_t quad_q[$];

    logic [12:0] width_reg, height_reg;
    logic        opaque_reg, normal_reg;
    int          pair_sums[PAIR_SLOTS][4];
    int          left_px[4];
    int          col, row;

    assign pending = quad_q.size();

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned res, bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv >>= 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x   = x - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // averaged RGB as a vector in [-1,1], Q2.14, scaled to unit length
    function automatic void renormalise(ref int avg[4]);
        longint          v[3];
        longint          num, n, biased;
        longint unsigned mag, sq, inv_len, o;
        sq = 0;
        for (int i = 0; i < 3; i++) begin
            num  = (longint'(avg[i]) * 2 - 255) * 16384;
            mag  = longint'(num < 0 ? -num : num) / 255;
            v[i] = num < 0 ? -longint'(mag) : longint'(mag);
            sq  += mag * mag;
        end
        if (sq == 0) return;
        inv_len = int_sqrt((64'd1 << 60) / sq);
        for (int i = 0; i < 3; i++) begin
            mag = v[i] < 0 ? -v[i] : v[i];
            n   = longint'((mag * inv_len) >> 16);
            if (v[i] < 0) n = -n;
            biased = n + 16384;
            if (biased < 0) biased = 0;
            o      = (longint'(biased) * 255) >> 15;
            avg[i] = o > 255 ? 255 : int'(o);
        end
    endfunction

    task automatic predict_pixel(input int px[4]);
        int          w, h, slot;
        int          pair[4], avg[4];
        quad_pixel_t q;
        w = width_reg < 1 ? 1 : (width_reg > MAX_WIDTH ? MAX_WIDTH : width_reg);
        h = height_reg < 1 ? 1 : (height_reg > HEIGHT_LIMIT ? HEIGHT_LIMIT : height_reg);
        if (opaque_reg) px[3] = 255;
        if (col % 2 == 0) begin
            left_px = px;
        end else begin
            slot = col / 2;
            for (int i = 0; i < 4; i++) pair[i] = left_px[i] + px[i];
            if (slot < PAIR_SLOTS) begin
                if (row % 2 == 0) begin
                    pair_sums[slot] = pair;
                end else begin
                    for (int i = 0; i < 4; i++)
                        avg[i] = ((pair_sums[slot][i] + pair[i]) >> 2) & 255;
                    if (normal_reg) renormalise(avg);
                    q.red   = 8'(avg[0]);
                    q.green = 8'(avg[1]);
                    q.blue  = 8'(avg[2]);
                    q.alpha = 8'(avg[3]);
                    q.last  = (slot == w / 2 - 1) && (row / 2 == h / 2 - 1);
                    quad_q.push_back(q);
                end
            end
        end
        col++;
        if (col >= w) begin
            col = 0;
            row++;
            if (row >= h) row = 0;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  = 13'd2;
            height_reg = 13'd2;
            opaque_reg = 1'b1;
            normal_reg = 1'b0;
            col        = 0;
            row        = 0;
            mismatches <= 0;
            quad_q.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_WIDTH: begin
                        width_reg = cfg_data;
                        col = 0;
                        row = 0;
                    end
                    REG_HEIGHT: begin
                        height_reg = cfg_data;
                        col = 0;
                        row = 0;
                    end
                    REG_OPAQUE: opaque_reg = cfg_data[0];
                    REG_NORMAL: normal_reg = cfg_data[0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                predict_pixel('{s_in_red, s_in_green, s_in_blue, s_in_alpha});
            if (m_valid && m_ready) begin
                if (quad_q.size() == 0) begin
                    if (mismatches < 10)
                        $display("%0t: unexpected output word %h %h %h %h last %b", $realtime,
                                 m_out_red, m_out_green, m_out_blue, m_out_alpha,
                                 m_last_of_level);
                    mismatches <= mismatches + 1;
                end else begin
                    quad_pixel_t q;
                    q = quad_q.pop_front();
                    if (q.red !== m_out_red || q.green !== m_out_green ||
                        q.blue !== m_out_blue || q.alpha !== m_out_alpha ||
                        q.last !== m_last_of_level) begin
                        if (mismatches < 10)
                            $display("%0t: rgba/last exp %h %h %h %h %b got %h %h %h %h %b",
                                     $realtime, q.red, q.green, q.blue, q.alpha, q.last,
                                     m_out_red, m_out_green, m_out_blue, m_out_alpha,
                                     m_last_of_level);
                        mismatches <= mismatches + 1;
                    end
                end
            end
        end
    end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Stimulus for the RGBA8 2x2 mip downsampler.
// Runs directed levels (channel extremes, odd sizes, saturated sizes, normal
// maps, size rewrite mid-level, a long output hold-off) and then random levels
// under random configuration with bursty input and a stalling output.
// ---------------------------------------------------------------------------
module tb_top;
    import rmbd_pkg::*;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_valid, s_ready;
    logic [7:0]            s_in_red, s_in_green, s_in_blue, s_in_alpha;
    logic                  m_valid, m_ready;
    logic [7:0]            m_out_red, m_out_green, m_out_blue, m_out_alpha;
    logic                  m_last_of_level;
    int                    mismatches, pending;
    logic                  hold_off;
    int                    burst_left;
    int                    stall_mode, stall_left;

    rgba8_mipmap_box_downsampler dut (.*);

    rmbd_quad_checker chk (.*);

    initial begin
        aclk = 1'b0;
    end
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        #20_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // output side stalls on its own pattern, switched every so often
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b0;
            stall_mode <= 0;
            stall_left <= 0;
        end else begin
            if (stall_left == 0) begin
                stall_mode <= $urandom_range(0, 3);
                stall_left <= $urandom_range(8, 120);
            end else begin
                stall_left <= stall_left - 1;
            end
            if (hold_off)
                m_ready <= 1'b0;
            else case (stall_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= ($urandom_range(0, 1) == 0);
                2: m_ready <= ($urandom_range(0, 4) != 0);
                default: m_ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(value);
        @(posedge aclk);
        cfg_we    <= 1'b0;
        @(posedge aclk);
    endtask

    // drain, then allow for a normal-map pass still in the back end
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (150) @(posedge aclk);
    endtask

    task automatic send_pixel(input logic [7:0] r, g, b, a);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 3) != 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid    <= 1'b1;
        s_in_red   <= r;
        s_in_green <= g;
        s_in_blue  <= b;
        s_in_alpha <= a;
        do @(negedge aclk); while (!s_ready);
        @(posedge aclk);
    endtask

    function automatic logic [7:0] chan_value();
        case ($urandom_range(0, 9))
            0: return 8'h00;
            1: return 8'hff;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_random(input int count);
        for (int i = 0; i < count; i++)
            send_pixel(chan_value(), chan_value(), chan_value(), chan_value());
    endtask

    task automatic set_size(input int w, input int h);
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
    endtask

    initial begin
        int w, h, n, random_items;
        aresetn    = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        s_valid    = 1'b0;
        s_in_red   = '0;
        s_in_green = '0;
        s_in_blue  = '0;
        s_in_alpha = '0;
        hold_off   = 1'b0;
        burst_left = 0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset setting: 2x2, opaque, colour
        repeat (4) send_pixel(8'h00, 8'h00, 8'h00, 8'h00);
        repeat (4) send_pixel(8'hff, 8'hff, 8'hff, 8'hff);
        send_pixel(8'hff, 8'h00, 8'h01, 8'h80);
        send_pixel(8'h00, 8'hff, 8'h02, 8'h7f);
        send_pixel(8'h03, 8'hfe, 8'hff, 8'h00);
        send_pixel(8'hff, 8'h01, 8'hfd, 8'hff);
        settle();

        // real alpha, odd trailing column and row
        write_reg(REG_OPAQUE, 0);
        set_size(5, 3);
        send_random(15);
        settle();

        // normal maps including both corners of the cube
        write_reg(REG_NORMAL, 1);
        set_size(2, 2);
        repeat (4) send_pixel(8'h00, 8'h00, 8'h00, 8'h00);
        repeat (4) send_pixel(8'hff, 8'hff, 8'hff, 8'h01);
        repeat (4) send_pixel(8'h80, 8'h80, 8'hff, 8'hfe);
        repeat (4) send_pixel(8'h7f, 8'h80, 8'h7f, 8'h55);
        settle();
        set_size(8, 4);
        send_random(32);
        settle();

        // long output hold-off so the block fills and stalls its input
        write_reg(REG_NORMAL, 0);
        set_size(8, 8);
        fork
            begin
                hold_off <= 1'b1;
                repeat (300) @(posedge aclk);
                hold_off <= 1'b0;
            end
            send_random(128);
        join
        settle();

        // size rewrite in the middle of a level restarts the position
        set_size(6, 4);
        send_random(9);
        settle();
        write_reg(REG_WIDTH, 4);
        send_random(16);
        settle();

        // saturated and degenerate sizes
        write_reg(REG_OPAQUE, 1);
        set_size(8191, 2);
        send_random(40);
        settle();
        set_size(4096, 2);
        send_random(40);
        settle();
        set_size(2, 8191);
        send_random(200);
        settle();
        set_size(0, 0);
        send_random(20);
        settle();
        set_size(1, 4096);
        send_random(40);
        settle();
        set_size(1, 1);
        send_random(8);
        settle();

        // random levels under random settings
        random_items = 0;
        while (random_items < 480) begin
            write_reg(REG_OPAQUE, $urandom_range(0, 1));
            write_reg(REG_NORMAL, ($urandom_range(0, 3) == 0));
            w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8191) % 64
                                           : $urandom_range(1, 12);
            h = $urandom_range(0, 9);
            set_size(w, h);
            if (w < 1) w = 1;
            if (h < 1) h = 1;
            n = w * h * $urandom_range(1, 3);
            if ($urandom_range(0, 5) == 0) n = $urandom_range(1, n);
            send_random(n);
            random_items += n;
            settle();
        end

        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
